// ===== hw/rtl/srw_pkg.sv =====
// shared types, constants and the checksum fold for the receive window block
// no dependencies
`default_nettype none

package srw_pkg;

  localparam logic [15:0] ACK_LEN   = 16'd4;
  localparam logic [4:0]  WS_RESET  = 5'd10;

  // register indexes, decoded from paddr[2]
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_TOTAL       = 1'b1;

  typedef struct packed {
    logic [4:0]  window_size;
    logic [31:0] packet_total;
  } cfg_t;

  typedef struct packed {
    logic load_beat;
    logic check;
    logic clr_pkt;
    logic mark;
    logic adv_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic adv_more;
  } stat_t;

  // fold carries twice into 16 bits, then complement
  function automatic logic [15:0] fold16(input logic [31:0] s);
    logic [16:0] a;
    logic [16:0] b;
    a = {1'b0, s[15:0]} + {1'b0, s[31:16]};
    b = {1'b0, a[15:0]} + {16'b0, a[16]};
    return ~b[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/srw_ifaces.sv =====
// valid/ready channel interfaces for packet beats and ack beats
// no dependencies
`default_nettype none

interface srw_pkt_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] sequence_number;
  logic [15:0] packet_length;
  logic [15:0] packet_checksum;
  logic [7:0]  data_byte;
  logic        last;

  modport source (output valid, action, sequence_number, packet_length,
                  packet_checksum, data_byte, last, input ready);
  modport sink   (input valid, action, sequence_number, packet_length,
                  packet_checksum, data_byte, last, output ready);
  modport mon    (input valid, ready, action, sequence_number, packet_length,
                  packet_checksum, data_byte, last);
endinterface

interface srw_ack_if;
  logic        valid;
  logic        ready;
  logic [31:0] ack_number;
  logic [15:0] ack_length;
  logic [15:0] ack_checksum;
  logic [31:0] window_base;
  logic        all_received;

  modport source (output valid, ack_number, ack_length, ack_checksum,
                  window_base, all_received, input ready);
  modport sink   (input valid, ack_number, ack_length, ack_checksum,
                  window_base, all_received, output ready);
  modport mon    (input valid, ready, ack_number, ack_length, ack_checksum,
                  window_base, all_received);
endinterface

`default_nettype wire

// ===== hw/rtl/srw_regs.sv =====
// apb-style configuration registers: window size and total packet count
// depends on srw_pkg
`default_nettype none

module srw_regs
  import srw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // byte lane bits are ignored, the word index is paddr[2]
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_size  <= WS_RESET;
      cfg.packet_total <= 32'd0;
    end else if (wr) begin
      unique case (paddr[2])
        REG_WINDOW_SIZE: cfg.window_size  <= pwdata[4:0];
        REG_TOTAL:       cfg.packet_total <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_SIZE: prdata = {27'd0, cfg.window_size};
      REG_TOTAL:       prdata = cfg.packet_total;
      default:         prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srw_ctrl.sv =====
// sequencer: beat intake, check, mark, window advance and ack load
// depends on srw_pkg
`default_nettype none

module srw_ctrl
  import srw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_last,
  output logic  in_ready,
  input  logic  out_ready,
  output logic  out_valid,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MARK  = 3'd2;
  localparam logic [2:0] S_ADV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_full;
  logic       out_full_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_beat = 1'b1;
          if (in_last) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_MARK;
      end
      S_MARK: begin
        cmd.clr_pkt = 1'b1;
        if (stat.take) begin
          cmd.mark   = 1'b1;
          state_next = S_ADV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ADV: begin
        if (stat.adv_more) cmd.adv_step = 1'b1;
        else               state_next   = S_OUT;
      end
      S_OUT: begin
        // wait for room in the ack register
        if (!out_full || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out)   out_full_next = 1'b1;
    else if (out_ready) out_full_next = 1'b0;
    else                out_full_next = out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srw_dp.sv =====
// datapath: running sum, held header, window compare, seen bitmap, base
// pointer and the ack output register; depends on srw_pkg
`default_nettype none

module srw_dp
  import srw_pkg::*;
#(
  parameter int MAX_WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        action,
  input  logic [31:0] sequence_number,
  input  logic [15:0] packet_length,
  input  logic [15:0] packet_checksum,
  input  logic [7:0]  data_byte,
  output logic [31:0] ack_number,
  output logic [15:0] ack_length,
  output logic [15:0] ack_checksum,
  output logic [31:0] window_base,
  output logic        all_received
);

  localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [31:0]           running_sum;
  logic [31:0]           held_seq;
  logic [15:0]           held_ck;
  logic [31:0]           base;
  logic [SW-1:0]         base_slot;
  logic [MAX_WINDOW-1:0] seen;
  logic                  good;
  logic                  in_win;
  logic [SW-1:0]         slot;
  logic [31:0]           res_seq;
  logic [15:0]           res_ck;

  logic [31:0]   ws32;
  logic [31:0]   eff_win;
  logic [31:0]   diff;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] slot_wrap;
  logic          win_ok;

  always_comb begin
    ws32 = {27'd0, cfg.window_size};
    if (ws32 == 32'd0)                  eff_win = 32'd1;
    else if (ws32 > 32'(MAX_WINDOW))    eff_win = 32'(MAX_WINDOW);
    else                                eff_win = ws32;
    diff   = held_seq - base;
    win_ok = (base < cfg.packet_total) && (held_seq >= base) &&
             (diff < eff_win) && (held_seq < cfg.packet_total);
    // offset from base is below the window, so one wrap at most
    slot_sum = {1'b0, base_slot} + {1'b0, diff[SW-1:0]};
    if (slot_sum >= (SW+1)'(MAX_WINDOW)) slot_wrap = SW'(slot_sum - (SW+1)'(MAX_WINDOW));
    else                                 slot_wrap = slot_sum[SW-1:0];
  end

  assign stat.take     = good && in_win && !seen[slot];
  assign stat.adv_more = (base < cfg.packet_total) && seen[base_slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 32'd0;
      held_seq    <= 32'd0;
      held_ck     <= 16'd0;
      base        <= 32'd0;
      base_slot   <= '0;
      seen        <= '0;
    end else begin
      if (cmd.load_beat) begin
        if (!action) begin
          held_seq    <= sequence_number;
          held_ck     <= packet_checksum;
          running_sum <= sequence_number + {16'd0, packet_length};
        end else begin
          running_sum <= running_sum + {24'd0, data_byte};
        end
      end
      if (cmd.clr_pkt) begin
        running_sum <= 32'd0;
        held_seq    <= 32'd0;
        held_ck     <= 16'd0;
      end
      if (cmd.mark) seen[slot] <= 1'b1;
      if (cmd.adv_step) begin
        seen[base_slot] <= 1'b0;
        base            <= base + 32'd1;
        if (base_slot == SW'(MAX_WINDOW - 1)) base_slot <= '0;
        else                                  base_slot <= base_slot + SW'(1);
      end
    end
  end

  // check results and ack fields, captured before the packet regs clear
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      good    <= (fold16(running_sum) == held_ck);
      in_win  <= win_ok;
      slot    <= slot_wrap;
      res_seq <= held_seq;
      res_ck  <= fold16(held_seq + {16'd0, ACK_LEN});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ack_number   <= res_seq;
      ack_length   <= ACK_LEN;
      ack_checksum <= res_ck;
      window_base  <= base;
      all_received <= (base >= cfg.packet_total);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/selective_repeat_receiver_window_top.sv =====
// top level of the selective repeat receive window
// depends on srw_pkg, srw_ifaces, srw_regs, srw_ctrl, srw_dp
//
//   channel | dir | handshake          | beat contents
//   pkt     | in  | valid/ready        | header or data byte, last ends packet
//   ack     | out | valid/ready        | ack number, length, checksum, base
//   apb     | in  | psel/penable/write | window_size @0x0, packet_total @0x4
//
// header and data beats are taken in the idle state; the last beat of a packet is followed
// by the check and mark states; an accepted packet then passes through the advance
// state, one step per slot passed, and the ack load state.
// the advance walks the seen bitmap one slot per cycle.
// rst clears base and bitmap at once; no clearing pass.
// pkt.ready is low from the last beat until the drop or the ack load; a stalled
// ack holds the block until the register frees.
`default_nettype none

module selective_repeat_receiver_window_top
  import srw_pkg::*;
#(
  parameter int MAX_WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  srw_pkt_if.sink     pkt,
  srw_ack_if.source   ack
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  out_valid;

  assign pkt.ready = in_ready;
  assign ack.valid = out_valid;

  srw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pkt.valid),
    .in_last   (pkt.last),
    .in_ready  (in_ready),
    .out_ready (ack.ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  srw_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .action          (pkt.action),
    .sequence_number (pkt.sequence_number),
    .packet_length   (pkt.packet_length),
    .packet_checksum (pkt.packet_checksum),
    .data_byte       (pkt.data_byte),
    .ack_number      (ack.ack_number),
    .ack_length      (ack.ack_length),
    .ack_checksum    (ack.ack_checksum),
    .window_base     (ack.window_base),
    .all_received    (ack.all_received)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/srw_checker.sv =====
// port-level checks on the receive window top, attached by bind
// depends on srw_pkg
`default_nettype none

module srw_checker
  import srw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        pkt_valid,
  input logic        pkt_ready,
  input logic        pkt_last,
  input logic        ack_valid,
  input logic        ack_ready,
  input logic [31:0] ack_number,
  input logic [15:0] ack_length,
  input logic [15:0] ack_checksum
);

  // the last beat of a packet closes the input while the packet is judged
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_ready && pkt_last |=> !pkt_ready)
    else $error("input open after last beat");

  // a beat inside a packet keeps the input open
  a_mid_open: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_ready && !pkt_last |=> pkt_ready)
    else $error("input closed after a mid-packet beat");

  a_ack_len: assert property (@(posedge clk) disable iff (rst)
    ack_valid |-> ack_length == ACK_LEN)
    else $error("ack length not 4");

  a_ack_sum: assert property (@(posedge clk) disable iff (rst)
    ack_valid |-> ack_checksum == fold16(ack_number + {16'd0, ACK_LEN}))
    else $error("ack checksum mismatch");

  a_ack_hold: assert property (@(posedge clk) disable iff (rst)
    ack_valid && !ack_ready |=> ack_valid && $stable(ack_number))
    else $error("stalled ack beat changed");

endmodule

bind selective_repeat_receiver_window_top srw_checker u_srw_checker (
  .clk          (clk),
  .rst          (rst),
  .pkt_valid    (pkt.valid),
  .pkt_ready    (pkt.ready),
  .pkt_last     (pkt.last),
  .ack_valid    (ack.valid),
  .ack_ready    (ack.ready),
  .ack_number   (ack.ack_number),
  .ack_length   (ack.ack_length),
  .ack_checksum (ack.ack_checksum)
);

`default_nettype wire
